>>> design/afce_pkg.sv
package afce_pkg;

   // Field widths fixed by the stream format
   localparam int WORD_W    = 32;
   localparam int SAMPLE_W  = 24;
   localparam int MAX_W     = 23;
   localparam int CHAN_W    = 8;
   localparam int BYTES_W   = 16;
   localparam int WLEFT_W   = 14;

   // Sample width default for the top level
   localparam int SAMPLE_BITS_DEFAULT = 24;

   // Stream constants
   localparam logic [WORD_W-1:0] SYNC_WORD = 32'hFFFF_FFFF;

   // Register reset values
   localparam logic [CHAN_W-1:0]  CHANNEL_ID_RESET = 8'hEA;
   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET  = 16'd1500;

   // Register indexes
   localparam logic REG_CHANNEL_ID = 1'b0;
   localparam logic REG_MAX_BYTES  = 1'b1;

   // Config bus widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Queue depth between stages and on the result side
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic [MAX_W-1:0]           max_first;
      logic [MAX_W-1:0]           max_second;
      logic signed [SAMPLE_W-1:0] min_first;
      logic signed [SAMPLE_W-1:0] min_second;
   } rsp_type;

   // Classified word handed from the parser to the tracker
   typedef struct packed {
      logic                       restart;
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } item_type;

endpackage

>>> design/afce_fifo.sv
module afce_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> design/afce_front.sv
module afce_front #(
   parameter int SAMPLE_BITS = afce_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  afce_pkg::req_type                req,
   input  logic [afce_pkg::CHAN_W-1:0]      channel_id,
   input  logic [afce_pkg::BYTES_W-1:0]     max_frame_bytes,
   output afce_pkg::item_type               item
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_SIZE    = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   logic [1:0]                     phase_ff, phase_in;
   logic [afce_pkg::WLEFT_W-1:0]   wleft_ff, wleft_in;
   logic [1:0]                     phase_cur;
   logic [afce_pkg::WLEFT_W-1:0]   wleft_cur;
   logic [afce_pkg::WLEFT_W-1:0]   wleft_dec;
   logic signed [afce_pkg::SAMPLE_W-1:0] sample_ext;
   logic                           hit;

   // Sign-extend the low SAMPLE_BITS bits of the word
   always_comb begin
      for (int i = 0; i < afce_pkg::SAMPLE_W; i++) begin
         sample_ext[i] = (i < SAMPLE_BITS) ? req.word[i] : req.word[SAMPLE_BITS-1];
      end
   end

   // Restart takes effect before this word is parsed
   assign phase_cur = req.restart ? PH_HUNT : phase_ff;
   assign wleft_cur = req.restart ? '0 : wleft_ff;
   assign hit       = (req.word[afce_pkg::WORD_W-1 -: afce_pkg::CHAN_W] == channel_id);
   assign wleft_dec = (wleft_cur != '0) ? wleft_cur - 1'b1 : wleft_cur;

   // Frame parser
   always_comb begin
      phase_in    = phase_cur;
      wleft_in    = wleft_cur;
      item.restart = req.restart;
      item.valid   = 1'b0;
      item.sample  = '0;
      case (phase_cur)
         PH_HUNT: begin
            if (req.word == afce_pkg::SYNC_WORD) begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            phase_in = req.word[afce_pkg::WORD_W-1] ? PH_HUNT : PH_SIZE;
         end
         PH_SIZE: begin
            if (req.word > {16'd0, max_frame_bytes}) begin
               phase_in = PH_HUNT;
            end else begin
               wleft_in = req.word[afce_pkg::WLEFT_W+1:2];
               phase_in = (req.word[afce_pkg::WLEFT_W+1:2] == '0) ? PH_HUNT : PH_PAYLOAD;
            end
         end
         default: begin
            if (hit) begin
               item.valid  = 1'b1;
               item.sample = sample_ext;
            end
            wleft_in = wleft_dec;
            if (wleft_dec == '0) begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         wleft_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wleft_ff <= wleft_in;
      end
   end

endmodule

>>> design/afce_back.sv
module afce_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_avail,
   input  afce_pkg::item_type   item,
   output logic                 item_take,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output afce_pkg::rsp_type    rsp
);

   typedef logic signed [afce_pkg::SAMPLE_W-1:0] val_type;

   val_type top_max_ff, top_max_in;
   val_type next_max_ff, next_max_in;
   val_type top_min_ff, top_min_in;
   val_type next_min_ff, next_min_in;
   val_type tmax, nmax, tmin, nmin, s;

   assign item_take = item_avail & ~rsp_full;
   assign rsp_push  = item_take;
   assign s         = item.sample;

   // Extrema update for one classified word
   always_comb begin
      tmax = item.restart ? '0 : top_max_ff;
      nmax = item.restart ? '0 : next_max_ff;
      tmin = item.restart ? '0 : top_min_ff;
      nmin = item.restart ? '0 : next_min_ff;
      top_max_in  = tmax;
      next_max_in = nmax;
      top_min_in  = tmin;
      next_min_in = nmin;
      if (item.valid) begin
         if (s > tmax) begin
            next_max_in = tmax;
            top_max_in  = s;
         end else if (s < tmax && s > nmax) begin
            next_max_in = s;
         end
         if (s < tmin) begin
            next_min_in = tmin;
            top_min_in  = s;
         end else if (s > tmin && s < nmin) begin
            next_min_in = s;
         end
      end
   end

   // Result transaction
   always_comb begin
      rsp.sample_valid = item.valid;
      rsp.sample       = item.sample;
      rsp.max_first    = top_max_in[afce_pkg::MAX_W-1:0];
      rsp.max_second   = next_max_in[afce_pkg::MAX_W-1:0];
      rsp.min_first    = top_min_in;
      rsp.min_second   = next_min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_max_ff  <= '0;
         next_max_ff <= '0;
         top_min_ff  <= '0;
         next_min_ff <= '0;
      end else if (item_take) begin
         top_max_ff  <= top_max_in;
         next_max_ff <= next_max_in;
         top_min_ff  <= top_min_in;
         next_min_ff <= next_min_in;
      end
   end

endmodule

>>> design/adc_frame_channel_extrema_core.sv
// Framed ADC stream parser with running channel extrema.
// Input queue side: req_data carries one 32-bit stream word and a restart
// flag; a transaction completes on a clock edge with push high and full low.
// Result queue side: rsp_data holds the oldest result while empty is low; a
// transaction completes on a clock edge with pop high and empty low. Each
// input word yields exactly one result: the sample if the word was a payload
// word of the selected channel, plus the current top two maxima and minima.
// The parser writes each accepted word's item into the middle queue; the
// tracker writes its result into the result queue, which drives rsp_data.
// Throughput: one word per cycle while full stays low; two-entry queues
// between the parser and tracker and after the tracker absorb stalls.
// When pop stays low the result queue fills, the tracker holds, the middle
// queue fills, and full rises; no result is dropped.
// Reset (synchronous) empties both queues, puts the parser in sync hunt,
// clears all extrema and loads channel_id = 0xEA, max_frame_bytes = 1500.
// Registers: channel_id at byte address 0, max_frame_bytes at address 4.
module adc_frame_channel_extrema_core #(
   parameter int SAMPLE_BITS = afce_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  afce_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output afce_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [afce_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [afce_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [afce_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   logic [afce_pkg::CHAN_W-1:0]  channel_id_ff, channel_id_in;
   logic [afce_pkg::BYTES_W-1:0] max_bytes_ff, max_bytes_in;
   logic                         csr_wr;
   logic                         reg_sel;

   afce_pkg::item_type front_item, back_item;
   afce_pkg::rsp_type  back_rsp;
   logic               accept, mid_full, mid_empty, item_take, rsp_full, rsp_push;

   // Config registers
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      channel_id_in = channel_id_ff;
      max_bytes_in  = max_bytes_ff;
      prdata        = '0;
      case (reg_sel)
         afce_pkg::REG_CHANNEL_ID: begin
            prdata = {24'd0, channel_id_ff};
            if (csr_wr) begin
               channel_id_in = pwdata[afce_pkg::CHAN_W-1:0];
            end
         end
         afce_pkg::REG_MAX_BYTES: begin
            prdata = {16'd0, max_bytes_ff};
            if (csr_wr) begin
               max_bytes_in = pwdata[afce_pkg::BYTES_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_id_ff <= afce_pkg::CHANNEL_ID_RESET;
         max_bytes_ff  <= afce_pkg::MAX_BYTES_RESET;
      end else begin
         channel_id_ff <= channel_id_in;
         max_bytes_ff  <= max_bytes_in;
      end
   end

   // Front: parse and classify
   assign full   = mid_full;
   assign accept = push & ~mid_full;

   afce_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req             (req_data),
      .channel_id      (channel_id_ff),
      .max_frame_bytes (max_bytes_ff),
      .item            (front_item)
   );

   // Queue between parser and tracker
   afce_fifo #(
      .WIDTH ($bits(afce_pkg::item_type)),
      .DEPTH (afce_pkg::QUEUE_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_item),
      .full    (mid_full),
      .rd_en   (item_take),
      .rd_data (back_item),
      .empty   (mid_empty)
   );

   // Back: extrema tracking
   afce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_avail (~mid_empty),
      .item       (back_item),
      .item_take  (item_take),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (back_rsp)
   );

   // Result queue
   afce_fifo #(
      .WIDTH ($bits(afce_pkg::rsp_type)),
      .DEPTH (afce_pkg::QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule
